// File: src/key_to_slot_offset_allocator_defines.svh
// Assertion macros shared by the checker of the key to slot offset allocator.
// Depends on nothing; take it in by include with the bare file name.
`ifndef KEY_TO_SLOT_OFFSET_ALLOCATOR_DEFINES_SVH
`define KEY_TO_SLOT_OFFSET_ALLOCATOR_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define KTSO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define KTSO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ktso_pkg.sv
// Package of the key to slot offset allocator: sizes, codes and struct types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ktso_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int OFS_W   = 31;
  localparam int ROW_W   = 16;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL = 2'd2;

  localparam logic [STAT_W-1:0] STAT_HIT     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_MISS    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FRESH   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_REUSED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_DELETED = 3'd4;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

  localparam logic [ROW_W-1:0] ROW_SIZE_RESET = 16'd1;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OFS_W-1:0]  offset;
  } out_item_t;

  // Lookup token that walks the cell chain.
  typedef struct packed {
    logic              active;
    logic [KEY_W-1:0]  key;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [OFS_W-1:0]  hit_ofs;
    logic              free;
    logic [IDX_W-1:0]  free_idx;
  } probe_t;

  // Table update broadcast to all cells.
  typedef struct packed {
    logic              set;
    logic              clear;
    logic [IDX_W-1:0]  idx;
    logic [KEY_W-1:0]  key;
    logic [OFS_W-1:0]  ofs;
  } commit_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [OFS_W-1:0]  data;
  } stack_ctl_t;

endpackage

`default_nettype wire

// File: src/ktso_cell.sv
// One table entry of the allocator chain: valid, key and offset of a slot.
// Depends on ktso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktso_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ktso_pkg::IDX_W-1:0] cell_idx,
  input  wire ktso_pkg::probe_t  probe_in,
  input  wire ktso_pkg::commit_t commit,
  output ktso_pkg::probe_t       probe_out
);
  import ktso_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;
  logic [OFS_W-1:0] ofs;
  logic             sel;
  probe_t           probe_next;

  assign sel = (commit.idx == cell_idx);

  always_comb begin
    probe_next = probe_in;
    if (!probe_in.hit && valid && (key == probe_in.key)) begin
      probe_next.hit     = 1'b1;
      probe_next.hit_idx = cell_idx;
      probe_next.hit_ofs = ofs;
    end
    if (!probe_in.free && !valid) begin
      probe_next.free     = 1'b1;
      probe_next.free_idx = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && commit.set) begin
      valid <= 1'b1;
    end else if (sel && commit.clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && commit.set) begin
      key <= commit.key;
      ofs <= commit.ofs;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

`default_nettype wire

// File: src/ktso_stack.sv
// LIFO stack of freed offsets with its fill count and a registered top read.
// Depends on ktso_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktso_stack (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ktso_pkg::stack_ctl_t ctl,
  output logic [ktso_pkg::OFS_W-1:0] top,
  output logic [ktso_pkg::CNT_W-1:0] count
);
  import ktso_pkg::*;

  logic [OFS_W-1:0] mem [ENTRIES];
  logic [CNT_W-1:0] top_addr;

  assign top_addr = count - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[count[IDX_W-1:0]] <= ctl.data;
    end
    top <= mem[top_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/key_to_slot_offset_allocator.sv
// Path: an accepted item is registered as the head token, passes every cell
//   register, is caught in res, and loads the output register once that is free.
// The token walks the chain one cell per cycle; one item is in the chain at a time.
// A waiting result does not block the next item; it blocks only the next result.
// Reset (rst, synchronous): entry valid bits, free count and bump cursor clear at
//   once, row_size returns to 1; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module key_to_slot_offset_allocator (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [ktso_pkg::ROW_W-1:0] cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ktso_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ktso_pkg::out_item_t       out_item
);
  import ktso_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [ROW_W-1:0] row_size;
  logic [OFS_W-1:0] cursor;
  logic [OFS_W-1:0] cursor_next;
  logic [CMD_W-1:0] cmd;
  probe_t           probe_head;
  probe_t           res;
  probe_t           chain [ENTRIES];
  commit_t          commit;
  stack_ctl_t       stack_ctl;
  logic [OFS_W-1:0] stack_top;
  logic [CNT_W-1:0] free_count;
  logic [OFS_W:0]   bump_sum;
  logic             accept;
  logic             fire;
  logic [STAT_W-1:0] stat;
  logic [OFS_W-1:0]  ofs;

  // Input side: take an item only when no item is in the chain.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Result may leave when the output register is empty or being drained.
  assign fire = (state == S_DECIDE) && (!out_valid || !out_stall);

  // Row size register; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_size <= ROW_SIZE_RESET;
    end else if (cfg_wen) begin
      row_size <= cfg_wdata;
    end
  end

  // Launch the lookup token into the head of the chain.
  always_ff @(posedge clk) begin
    probe_head.key      <= in_item.key;
    probe_head.hit      <= 1'b0;
    probe_head.hit_idx  <= '0;
    probe_head.hit_ofs  <= '0;
    probe_head.free     <= 1'b0;
    probe_head.free_idx <= '0;
    if (rst) begin
      probe_head.active <= 1'b0;
    end else begin
      probe_head.active <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_item.cmd;
    end
  end

  // Chain of table cells; cell 0 sees the token first, so the lowest slot wins.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      ktso_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (IDX_W'(i)),
        .probe_in (probe_head),
        .commit   (commit),
        .probe_out(chain[i])
      );
    end else begin : g_body
      ktso_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (IDX_W'(i)),
        .probe_in (chain[i-1]),
        .commit   (commit),
        .probe_out(chain[i])
      );
    end
  end

  // Catch the token as it leaves the last cell.
  always_ff @(posedge clk) begin
    if (state == S_WALK && chain[ENTRIES-1].active) begin
      res <= chain[ENTRIES-1];
    end
  end

  ktso_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctl  (stack_ctl),
    .top  (stack_top),
    .count(free_count)
  );

  // Fresh allocation: cursor plus row size, one carry bit to flag overflow.
  assign bump_sum = {1'b0, cursor} + (OFS_W + 1)'(row_size);

  // Decide the result and the table, stack and cursor updates.
  always_comb begin
    stat           = STAT_MISS;
    ofs            = '0;
    cursor_next    = cursor;
    commit.set     = 1'b0;
    commit.clear   = 1'b0;
    commit.idx     = res.hit_idx;
    commit.key     = res.key;
    commit.ofs     = '0;
    stack_ctl.push = 1'b0;
    stack_ctl.pop  = 1'b0;
    stack_ctl.data = res.hit_ofs;
    unique case (cmd)
      CMD_ADD: begin
        if (res.hit) begin
          stat = STAT_HIT;
          ofs  = res.hit_ofs;
        end else if (!res.free) begin
          stat = STAT_FULL;
        end else if (free_count != '0) begin
          // Reuse the most recently freed offset.
          stat          = STAT_REUSED;
          ofs           = stack_top;
          commit.set    = 1'b1;
          commit.idx    = res.free_idx;
          commit.ofs    = stack_top;
          stack_ctl.pop = 1'b1;
        end else if (bump_sum[OFS_W]) begin
          stat = STAT_FULL;
        end else begin
          stat        = STAT_FRESH;
          ofs         = cursor;
          commit.set  = 1'b1;
          commit.idx  = res.free_idx;
          commit.ofs  = cursor;
          cursor_next = bump_sum[OFS_W-1:0];
        end
      end
      CMD_GET: begin
        if (res.hit) begin
          stat = STAT_HIT;
          ofs  = res.hit_ofs;
        end
      end
      CMD_DEL: begin
        if (res.hit) begin
          stat           = STAT_DELETED;
          ofs            = res.hit_ofs;
          commit.clear   = 1'b1;
          stack_ctl.push = (free_count != CNT_W'(ENTRIES));
        end
      end
      default: begin
        stat = STAT_MISS;
      end
    endcase
    // Hold everything unless the result is leaving this cycle.
    if (!fire) begin
      commit.set     = 1'b0;
      commit.clear   = 1'b0;
      stack_ctl.push = 1'b0;
      stack_ctl.pop  = 1'b0;
      cursor_next    = cursor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      cursor <= cursor_next;
    end
  end

  // Sequencer: idle, walk the chain, then deliver.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_WALK;
      S_WALK:   if (chain[ENTRIES-1].active) state_next = S_DECIDE;
      S_DECIDE: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: load on fire, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.status <= stat;
      out_item.offset <= ofs;
    end
  end

endmodule

`default_nettype wire

// File: src/ktso_checker.sv
// Port-level checker of the key to slot offset allocator, bound to the top level.
// Depends on ktso_pkg and key_to_slot_offset_allocator_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "key_to_slot_offset_allocator_defines.svh"

module ktso_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire ktso_pkg::in_item_t  in_item,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire ktso_pkg::out_item_t out_item
);
  import ktso_pkg::*;

  logic in_take;
  assign in_take = in_valid && !in_stall && (in_item.cmd == in_item.cmd);

  `KTSO_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")
  `KTSO_ASSERT(a_busy_after_take, clk, rst, in_take |=> in_stall, "item taken while another is in the chain")
  `KTSO_ASSERT(a_zero_ofs, clk, rst, out_valid && (out_item.status == STAT_MISS || out_item.status == STAT_FULL) |-> out_item.offset == '0, "miss or full carries an offset")
  `KTSO_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "result shown right after reset")

endmodule

bind key_to_slot_offset_allocator ktso_checker u_checker (.*);

`default_nettype wire

// File: dv/ktso_binding_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the key to slot offset allocator: keeps its own key table,
// freed-offset stack and bump cursor, and checks every result item in order.
// Depends on ktso_pkg for sizes, codes and the item types.
module ktso_binding_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [ktso_pkg::ROW_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire ktso_pkg::in_item_t         in_item,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire ktso_pkg::out_item_t        out_item,
  output int                              errors,
  output int                              outstanding
);
  import ktso_pkg::*;

  logic             slot_used [ENTRIES];
  logic [KEY_W-1:0] slot_key  [ENTRIES];
  logic [OFS_W-1:0] slot_ofs  [ENTRIES];
  logic [OFS_W-1:0] freed_ofs [ENTRIES];
  int               freed_cnt;
  logic [OFS_W-1:0] cursor;
  logic [ROW_W-1:0] row_size;

  out_item_t expected_bindings[$];

  // Apply one command to the table copy and return the result it yields.
  function automatic out_item_t bind_offset(input in_item_t item);
    out_item_t      r;
    int             hit;
    int             slot;
    int             i;
    logic [OFS_W:0] nxt;
    r.status = STAT_MISS;
    r.offset = '0;
    hit = -1;
    slot = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == item.key) hit = i;
      if (slot < 0 && !slot_used[i]) slot = i;
    end
    case (item.cmd)
      CMD_ADD: begin
        if (hit >= 0) begin
          r.status = STAT_HIT;
          r.offset = slot_ofs[hit];
        end else if (slot < 0) begin
          r.status = STAT_FULL;
        end else if (freed_cnt > 0) begin
          freed_cnt--;
          r.status = STAT_REUSED;
          r.offset = freed_ofs[freed_cnt];
          slot_used[slot] = 1'b1;
          slot_key[slot] = item.key;
          slot_ofs[slot] = r.offset;
        end else begin
          nxt = {1'b0, cursor} + {{(OFS_W + 1 - ROW_W){1'b0}}, row_size};
          if (nxt[OFS_W]) begin
            r.status = STAT_FULL;
          end else begin
            r.status = STAT_FRESH;
            r.offset = cursor;
            slot_used[slot] = 1'b1;
            slot_key[slot] = item.key;
            slot_ofs[slot] = cursor;
            cursor = nxt[OFS_W-1:0];
          end
        end
      end
      CMD_GET: begin
        if (hit >= 0) begin
          r.status = STAT_HIT;
          r.offset = slot_ofs[hit];
        end
      end
      CMD_DEL: begin
        if (hit >= 0) begin
          r.status = STAT_DELETED;
          r.offset = slot_ofs[hit];
          if (freed_cnt < ENTRIES) begin
            freed_ofs[freed_cnt] = r.offset;
            freed_cnt++;
          end
          slot_used[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    errors = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      freed_cnt = 0;
      cursor = '0;
      row_size = ROW_SIZE_RESET;
      expected_bindings.delete();
    end else begin
      if (cfg_wen) row_size = cfg_wdata;
      if (in_valid && !in_stall) begin
        want = bind_offset(in_item);
        expected_bindings = {expected_bindings, want};
      end
      if (out_valid && !out_stall) begin
        if (expected_bindings.size() == 0) begin
          $display("%0t: result with none expected, actual status %0d offset %0d",
                   $time, out_item.status, out_item.offset);
          errors++;
        end else begin
          want = expected_bindings.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_item.status);
            errors++;
          end
          if (out_item.offset !== want.offset) begin
            $display("%0t: offset mismatch, expected %0d, actual %0d",
                     $time, want.offset, out_item.offset);
            errors++;
          end
        end
      end
    end
    outstanding = expected_bindings.size();
  end

endmodule

// File: dv/tb_key_to_slot_offset_allocator.sv
`timescale 1ns / 1ps
// Top of the key to slot offset allocator bench: clock, reset, item and
// configuration stimulus, receiver stalls, watchdog and verdict.
// Depends on ktso_pkg, the block itself and ktso_binding_checker.
module tb_key_to_slot_offset_allocator;
  import ktso_pkg::*;

  // The block decodes only add, get and delete; the fourth code must act as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // A lookup walks the whole chain, so one item can keep both channels quiet
  // while it does; allow for that plus the longest gap and stall.
  localparam int QUIET_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_wen;
  logic [ROW_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_item;
  int                   errors;
  int                   outstanding;
  int                   quiet_cycles;
  // Suppress both sender gaps and receiver stalls while set.
  logic                 calm = 1'b0;
  logic [KEY_W-1:0]     key_pool[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  key_to_slot_offset_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  ktso_binding_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (!rst && quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: stall at random, mostly short bursts, now and then a long one.
  initial begin
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rst || calm) begin
        out_stall = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if ($urandom_range(0, 99) < 6) begin
        out_stall = 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 3);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Idle cycles before the next item: none most of the time, a few long waits.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Present one item from a falling edge and hold it until accepted; return
  // at the following falling edge with valid dropped.
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    in_item.cmd = c;
    in_item.key = k;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Write row_size only with the table idle: drain, settle, then pulse the enable.
  task automatic set_row_size(input logic [ROW_W-1:0] v);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_wdata = v;
    cfg_wen = 1'b1;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  task automatic new_pool(input int n);
    key_pool.delete();
    repeat (n) key_pool = {key_pool, KEY_W'($urandom)};
    key_pool = {key_pool, 32'h8000_0000};
    key_pool = {key_pool, 32'h7fff_ffff};
    key_pool = {key_pool, 32'hffff_ffff};
    key_pool = {key_pool, 32'h0000_0000};
  endtask

  // Mixed traffic: mostly keys from the pool so adds hit, deletes free and
  // re-adds reuse; some fresh random keys and the unused code as noise.
  task automatic run_mix(input int n);
    int               r;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) c = CMD_ADD;
      else if (r < 65) c = CMD_GET;
      else if (r < 95) c = CMD_DEL;
      else c = CMD_UNUSED;
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      else k = $urandom;
      send_item(c, k);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part with the reset row size: extreme keys, hit on re-add,
    // get and delete of absent keys, LIFO reuse of freed offsets, no-op code.
    send_item(CMD_ADD, 32'h8000_0000);
    send_item(CMD_ADD, 32'h7fff_ffff);
    send_item(CMD_ADD, 32'hffff_ffff);
    send_item(CMD_ADD, 32'h0000_0000);
    send_item(CMD_ADD, 32'h8000_0000);
    send_item(CMD_GET, 32'h7fff_ffff);
    send_item(CMD_GET, 32'h1234_5678);
    send_item(CMD_DEL, 32'h8000_0000);
    send_item(CMD_DEL, 32'h0000_0000);
    send_item(CMD_DEL, 32'h8000_0000);
    send_item(CMD_GET, 32'h8000_0000);
    send_item(CMD_ADD, 32'haaaa_aaaa);
    send_item(CMD_ADD, 32'h5555_5555);
    send_item(CMD_ADD, 32'h0000_0001);
    send_item(CMD_UNUSED, 32'hffff_ffff);
    send_item(CMD_UNUSED, 32'h0000_0000);
    send_item(CMD_GET, 32'hffff_fffe);
    send_item(CMD_DEL, 32'hffff_ffff);
    send_item(CMD_ADD, 32'hffff_ffff);

    // Largest row size.
    set_row_size(16'hffff);
    new_pool(20);
    run_mix(150);

    // Zero row size: fresh allocations repeat the cursor.
    set_row_size(16'h0000);
    new_pool(16);
    run_mix(100);

    // Fill the table until adds report full; the first stretch runs without
    // gaps or stalls.
    set_row_size(ROW_W'($urandom_range(1, 65535)));
    key_pool.delete();
    calm = 1'b1;
    repeat (100) begin
      key_pool = {key_pool, KEY_W'($urandom)};
      send_item(CMD_ADD, key_pool[key_pool.size() - 1]);
    end
    calm = 1'b0;
    repeat (170) begin
      key_pool = {key_pool, KEY_W'($urandom)};
      send_item(CMD_ADD, key_pool[key_pool.size() - 1]);
    end
    // Churn the full table: deletes open slots, re-adds pull from the stack.
    run_mix(100);

    // Back to the smallest row size.
    set_row_size(16'h0001);
    new_pool(26);
    run_mix(160);

    // Let every result arrive, then watch for strays over one more lookup time.
    wait_drained();
    repeat (ENTRIES + 8) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/ktso_pkg.sv
src/ktso_cell.sv
src/ktso_stack.sv
src/key_to_slot_offset_allocator.sv
src/ktso_checker.sv
dv/ktso_binding_checker.sv
dv/tb_key_to_slot_offset_allocator.sv
